FILE: design/ffba_pkg.sv
package ffba_pkg;

  localparam int HEAP_BYTES = 8192;
  localparam int ROW_BITS   = 32;
  localparam int ROWS       = HEAP_BYTES / ROW_BITS;
  localparam int ROW_AW     = $clog2(ROWS);
  localparam int BIT_AW     = $clog2(ROW_BITS);
  localparam int ADDR_W     = $clog2(HEAP_BYTES);
  localparam int SIZE_W     = ADDR_W + 1;

  typedef enum logic {
    OP_ALLOC = 1'b0,
    OP_FREE  = 1'b1
  } op_t;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_NULL    = 3'd1,
    ST_NOROOM  = 3'd2,
    ST_NOFIT   = 3'd3,
    ST_BADFREE = 3'd4
  } status_t;

  typedef struct packed {
    op_t                opcode;
    logic [SIZE_W-1:0]  elem_size;
    logic [SIZE_W-1:0]  elem_count;
    logic [ADDR_W-1:0]  block_offset;
    logic               clean;
  } req_t;

  typedef struct packed {
    status_t            status;
    logic [ADDR_W-1:0]  payload_offset;
    logic [SIZE_W-1:0]  used_total;
    logic [SIZE_W-1:0]  live_blocks;
  } rsp_t;

  // result of searching one free-map row
  typedef struct packed {
    logic               hit;
    logic [BIT_AW-1:0]  pos;
    logic [SIZE_W-1:0]  run;
  } scan_res_t;

endpackage

FILE: design/ffba_bitmap_ram.sv
module ffba_bitmap_ram #(
  parameter logic [31:0] FILL = 32'h0
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [ffba_pkg::ROW_AW-1:0]   rd_addr,
  output logic [ffba_pkg::ROW_BITS-1:0] rd_data,
  input  logic                          wr_en,
  input  logic [ffba_pkg::ROW_AW-1:0]   wr_addr,
  input  logic [ffba_pkg::ROW_BITS-1:0] wr_data
);
  import ffba_pkg::*;

  logic [ROW_BITS-1:0] mem [ROWS];
  logic [ROWS-1:0]     vld;
  logic [ROW_BITS-1:0] mem_q;
  logic                vld_q;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    mem_q <= mem[rd_addr];
  end

  // row never written reads as its reset pattern
  always_ff @(posedge clk) begin
    if (rst) begin
      vld   <= '0;
      vld_q <= 1'b0;
    end else begin
      if (wr_en) begin
        vld[wr_addr] <= 1'b1;
      end
      vld_q <= vld[rd_addr];
    end
  end

  assign rd_data = vld_q ? mem_q : FILL[ROW_BITS-1:0];

endmodule

FILE: design/ffba_len_ram.sv
module ffba_len_ram (
  input  logic                        clk,
  input  logic [ffba_pkg::ADDR_W-1:0] rd_addr,
  output logic [ffba_pkg::SIZE_W-1:0] rd_data,
  input  logic                        wr_en,
  input  logic [ffba_pkg::ADDR_W-1:0] wr_addr,
  input  logic [ffba_pkg::SIZE_W-1:0] wr_data
);
  import ffba_pkg::*;

  logic [SIZE_W-1:0] mem [HEAP_BYTES];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

FILE: design/ffba_row_scan.sv
module ffba_row_scan (
  input  logic [ffba_pkg::ROW_BITS-1:0] row,
  input  logic [ffba_pkg::SIZE_W-1:0]   run_in,
  input  logic [ffba_pkg::SIZE_W-1:0]   need,
  input  logic [ffba_pkg::BIT_AW:0]     nbits,
  output ffba_pkg::scan_res_t           res
);
  import ffba_pkg::*;

  logic [ROW_BITS:0]   lowmask;
  logic [ROW_BITS-1:0] f;
  logic [ROW_BITS-1:0] hit;
  logic [ROW_BITS-1:0] win [ROW_BITS];
  logic [BIT_AW:0]     lo  [ROW_BITS];
  logic [BIT_AW-1:0]   top_zero;
  logic [BIT_AW-1:0]   pos;

  always_comb begin
    // bits at or beyond the heap limit count as used
    lowmask = ((ROW_BITS+1)'(1) << nbits) - (ROW_BITS+1)'(1);
    f       = row & lowmask[ROW_BITS-1:0];
    for (int j = 0; j < ROW_BITS; j++) begin
      // window of the last need bits ending at j, clipped to this row
      if ({1'b0, need} <= (SIZE_W+1)'(j + 1)) begin
        lo[j] = (BIT_AW+1)'((SIZE_W+1)'(j + 1) - {1'b0, need});
      end else begin
        lo[j] = '0;
      end
      win[j] = ~((ROW_BITS'(1) << lo[j]) - ROW_BITS'(1))
               & ({ROW_BITS{1'b1}} >> (ROW_BITS - 1 - j));
      hit[j] = ((~f & win[j]) == '0)
               && (({1'b0, run_in} + (SIZE_W+1)'(j + 1)) >= {1'b0, need});
    end
  end

  always_comb begin
    pos      = '0;
    top_zero = '0;
    for (int j = ROW_BITS - 1; j >= 0; j--) begin
      if (hit[j]) begin
        pos = BIT_AW'(j);
      end
    end
    for (int j = 0; j < ROW_BITS; j++) begin
      if (!f[j]) begin
        top_zero = BIT_AW'(j);
      end
    end
    res.hit = |hit;
    res.pos = pos;
    if (&f) begin
      res.run = run_in + SIZE_W'(ROW_BITS);
    end else begin
      res.run = SIZE_W'(ROW_BITS - 1) - SIZE_W'(top_zero);
    end
  end

endmodule

FILE: design/first_fit_byte_map_allocator.sv
// channel  dir  handshake              payload
// req      in   req_valid / req_stall  req (opcode, sizes, offset, clean)
// rsp      out  rsp_valid / rsp_stall  rsp (status, offset, used, live)
// cfg      in   cfg_valid / cfg_ready  cfg_data (heap_size)
//
// One item at a time; each ends in the final state, which loads the result. Allocate: idle,
// multiply and room check, then the scan reads one 32-byte free-map row per cycle, then a
// read-write pair per row touched, then one for the start mark. Free: idle, header read, wait
// and mark check, plus a start-mark write and a read-write pair per row touched when clean.
// Errors: idle (null, bad offset), room check (no room), mark check (no start mark), full scan
// (no run). Reset is synchronous; memories need no clearing pass (row valid bits). A stalled
// result holds the block in its final state; req_stall is high whenever an item is in progress.
module first_fit_byte_map_allocator #(
  parameter int HEADER_BYTES = 16
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        req_valid,
  output logic                        req_stall,
  input  ffba_pkg::req_t              req,
  output logic                        rsp_valid,
  input  logic                        rsp_stall,
  output ffba_pkg::rsp_t              rsp,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [ffba_pkg::SIZE_W-1:0] cfg_data
);
  import ffba_pkg::*;

  localparam logic [SIZE_W-1:0] HDR     = SIZE_W'(HEADER_BYTES);
  localparam logic [SIZE_W-1:0] HEAP_SZ = SIZE_W'(HEAP_BYTES);
  localparam int                PROD_W  = 2 * SIZE_W;

  typedef enum logic [3:0] {
    S_IDLE, S_MUL, S_CHK, S_SCAN, S_FM_RD, S_FM_WR,
    S_SM_RD, S_SM_WR, S_FR_RD, S_FR_WT, S_FR_CHK, S_FIN
  } state_t;

  state_t              state;
  logic [SIZE_W-1:0]   heap_size;
  op_t                 op;
  logic [SIZE_W-1:0]   esize;
  logic [SIZE_W-1:0]   ecount;
  logic [ADDR_W-1:0]   boff;
  logic                clean_q;
  logic [PROD_W-1:0]   prod;
  logic [SIZE_W-1:0]   need;
  logic [SIZE_W-1:0]   used;
  logic [SIZE_W-1:0]   live;
  logic [ROW_AW:0]     scan_row;
  logic                eval_vld;
  logic [ROW_AW-1:0]   eval_row;
  logic [SIZE_W-1:0]   run;
  logic [ROW_AW-1:0]   cur_row;
  logic [ADDR_W-1:0]   rng_lo;
  logic [ADDR_W-1:0]   rng_hi;
  logic [ADDR_W-1:0]   mark_pos;
  status_t             res_status;
  logic [ADDR_W-1:0]   res_off;

  logic [SIZE_W-1:0]   limit;
  logic [PROD_W:0]     need_wide;
  logic [SIZE_W-1:0]   room;
  logic                can_issue;
  logic [SIZE_W-1:0]   eval_base;
  logic [SIZE_W-1:0]   diff;
  logic [BIT_AW:0]     nbits;
  scan_res_t           sres;
  logic [SIZE_W:0]     s_wide;
  logic [SIZE_W-1:0]   boff_w;
  logic [SIZE_W-1:0]   hdr_w;
  logic [SIZE_W+1:0]   end_wide;
  logic [BIT_AW-1:0]   lo_b;
  logic [BIT_AW-1:0]   hi_b;
  logic [ROW_BITS-1:0] rmask;
  logic [ROW_BITS-1:0] mark_bit;
  logic [ROW_AW-1:0]   fm_rd_addr;
  logic [ROW_BITS-1:0] fm_rd;
  logic [ROW_BITS-1:0] fm_wdata;
  logic [ROW_BITS-1:0] sm_rd;
  logic [ROW_BITS-1:0] sm_wdata;
  logic [SIZE_W-1:0]   bb_rd;
  logic                rsp_take;

  assign limit     = (heap_size > HEAP_SZ) ? HEAP_SZ : heap_size;
  assign need_wide = {1'b0, prod} + (PROD_W+1)'(HEADER_BYTES);
  assign room      = (used >= limit) ? '0 : limit - used;
  assign can_issue = {scan_row, BIT_AW'(0)} < (SIZE_W+1)'(limit);
  assign eval_base = {eval_row, BIT_AW'(0)};
  assign diff      = limit - eval_base;
  assign nbits     = (diff >= SIZE_W'(ROW_BITS)) ? (BIT_AW+1)'(ROW_BITS)
                                                 : diff[BIT_AW:0];
  assign s_wide    = {1'b0, eval_base} + (SIZE_W+1)'(sres.pos) + (SIZE_W+1)'(1)
                     - {1'b0, need};
  assign boff_w    = {1'b0, boff};
  assign hdr_w     = boff_w - HDR;
  assign end_wide  = (SIZE_W+2)'(mark_pos) + (SIZE_W+2)'(bb_rd) - (SIZE_W+2)'(1);

  assign lo_b     = (cur_row == rng_lo[ADDR_W-1:BIT_AW]) ? rng_lo[BIT_AW-1:0] : '0;
  assign hi_b     = (cur_row == rng_hi[ADDR_W-1:BIT_AW]) ? rng_hi[BIT_AW-1:0] : '1;
  assign rmask    = ({ROW_BITS{1'b1}} << lo_b)
                    & ({ROW_BITS{1'b1}} >> (BIT_AW'(ROW_BITS - 1) - hi_b));
  assign mark_bit = ROW_BITS'(1) << mark_pos[BIT_AW-1:0];

  assign fm_rd_addr = (state == S_SCAN) ? scan_row[ROW_AW-1:0] : cur_row;
  assign fm_wdata   = (op == OP_FREE) ? (fm_rd | rmask) : (fm_rd & ~rmask);
  assign sm_wdata   = (op == OP_FREE) ? (sm_rd & ~mark_bit) : (sm_rd | mark_bit);

  ffba_bitmap_ram #(.FILL(32'hFFFF_FFFF)) u_free_map (
    .clk     (clk),
    .rst     (rst),
    .rd_addr (fm_rd_addr),
    .rd_data (fm_rd),
    .wr_en   (state == S_FM_WR),
    .wr_addr (cur_row),
    .wr_data (fm_wdata)
  );

  ffba_bitmap_ram #(.FILL(32'h0)) u_start_mark (
    .clk     (clk),
    .rst     (rst),
    .rd_addr (mark_pos[ADDR_W-1:BIT_AW]),
    .rd_data (sm_rd),
    .wr_en   (state == S_SM_WR),
    .wr_addr (mark_pos[ADDR_W-1:BIT_AW]),
    .wr_data (sm_wdata)
  );

  ffba_len_ram u_block_len (
    .clk     (clk),
    .rd_addr (mark_pos),
    .rd_data (bb_rd),
    .wr_en   ((state == S_SM_WR) && (op == OP_ALLOC)),
    .wr_addr (mark_pos),
    .wr_data (need)
  );

  ffba_row_scan u_scan (
    .row    (fm_rd),
    .run_in (run),
    .need   (need),
    .nbits  (nbits),
    .res    (sres)
  );

  assign req_stall = (state != S_IDLE);
  assign cfg_ready = 1'b1;
  assign rsp_take  = !rsp_valid || !rsp_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      heap_size <= HEAP_SZ;
      used      <= '0;
      live      <= '0;
      rsp_valid <= 1'b0;
      eval_vld  <= 1'b0;
    end else begin
      if (cfg_valid) begin
        heap_size <= cfg_data;
      end
      if ((state == S_FIN) && rsp_take) begin
        rsp_valid <= 1'b1;
      end else if (rsp_valid && !rsp_stall) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (req_valid) begin
            op      <= req.opcode;
            esize   <= req.elem_size;
            ecount  <= req.elem_count;
            boff    <= req.block_offset;
            clean_q <= req.clean;
            res_off <= '0;
            if (req.opcode == OP_ALLOC) begin
              if (req.elem_count == '0) begin
                res_status <= ST_NULL;
                state      <= S_FIN;
              end else begin
                state <= S_MUL;
              end
            end else begin
              priority if (req.block_offset == '0) begin
                res_status <= ST_NULL;
                state      <= S_FIN;
              end else if ({1'b0, req.block_offset} < HDR) begin
                res_status <= ST_BADFREE;
                state      <= S_FIN;
              end else if (({1'b0, req.block_offset} - HDR) >= limit) begin
                res_status <= ST_BADFREE;
                state      <= S_FIN;
              end else begin
                state <= S_FR_RD;
              end
            end
          end
        end
        S_MUL: begin
          prod  <= (esize != '0) ? esize * ecount : PROD_W'(ecount);
          state <= S_CHK;
        end
        S_CHK: begin
          need     <= need_wide[SIZE_W-1:0];
          scan_row <= '0;
          eval_vld <= 1'b0;
          run      <= '0;
          if (need_wide > (PROD_W+1)'(room)) begin
            res_status <= ST_NOROOM;
            state      <= S_FIN;
          end else begin
            state <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (eval_vld && sres.hit) begin
            rng_lo     <= s_wide[ADDR_W-1:0];
            rng_hi     <= ADDR_W'(s_wide[SIZE_W-1:0] + need - SIZE_W'(1));
            cur_row    <= s_wide[ADDR_W-1:BIT_AW];
            mark_pos   <= s_wide[ADDR_W-1:0];
            used       <= used + need;
            live       <= live + SIZE_W'(1);
            res_off    <= ADDR_W'(s_wide[SIZE_W-1:0] + HDR);
            res_status <= ST_OK;
            eval_vld   <= 1'b0;
            state      <= S_FM_RD;
          end else begin
            if (eval_vld) begin
              run <= sres.run;
            end
            if (can_issue) begin
              eval_vld <= 1'b1;
              eval_row <= scan_row[ROW_AW-1:0];
              scan_row <= scan_row + (ROW_AW+1)'(1);
            end else begin
              eval_vld <= 1'b0;
              if (!eval_vld) begin
                res_status <= ST_NOFIT;
                state      <= S_FIN;
              end
            end
          end
        end
        S_FM_RD: begin
          state <= S_FM_WR;
        end
        S_FM_WR: begin
          if (cur_row == rng_hi[ADDR_W-1:BIT_AW]) begin
            state <= (op == OP_ALLOC) ? S_SM_RD : S_FIN;
          end else begin
            cur_row <= cur_row + ROW_AW'(1);
            state   <= S_FM_RD;
          end
        end
        S_SM_RD: begin
          state <= S_SM_WR;
        end
        S_SM_WR: begin
          state <= (op == OP_ALLOC) ? S_FIN : S_FM_RD;
        end
        S_FR_RD: begin
          mark_pos <= hdr_w[ADDR_W-1:0];
          state    <= S_FR_WT;
        end
        S_FR_WT: begin
          state <= S_FR_CHK;
        end
        S_FR_CHK: begin
          // mark_pos was presented during the wait cycle; data is for it now
          if ((sm_rd & mark_bit) == '0) begin
            res_status <= ST_BADFREE;
            state      <= S_FIN;
          end else begin
            res_status <= ST_OK;
            used       <= (used > bb_rd) ? used - bb_rd : '0;
            live       <= live - SIZE_W'(1);
            rng_lo     <= mark_pos;
            rng_hi     <= (end_wide > (SIZE_W+2)'(HEAP_BYTES - 1))
                          ? ADDR_W'(HEAP_BYTES - 1) : end_wide[ADDR_W-1:0];
            cur_row    <= mark_pos[ADDR_W-1:BIT_AW];
            state      <= clean_q ? S_SM_WR : S_FIN;
          end
        end
        S_FIN: begin
          if (rsp_take) begin
            rsp.status         <= res_status;
            rsp.payload_offset <= res_off;
            rsp.used_total     <= used;
            rsp.live_blocks    <= live;
            state              <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_used_bounded: assert property (@(posedge clk) disable iff (rst)
    (state == S_FIN) |-> (used <= HEAP_SZ))
    else $error("used count beyond heap");

  a_scan_in_limit: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN && eval_vld) |-> (eval_base < limit))
    else $error("scan row past heap limit");

  a_row_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_FM_WR) |-> (cur_row >= rng_lo[ADDR_W-1:BIT_AW]
                            && cur_row <= rng_hi[ADDR_W-1:BIT_AW]))
    else $error("free-map write outside block");

  a_alloc_off: assert property (@(posedge clk) disable iff (rst)
    (state == S_FIN && op == OP_ALLOC && res_status == ST_OK)
      |-> ({1'b0, res_off} >= HDR))
    else $error("payload offset below header");

  a_rsp_load: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> ($past(state) == S_FIN))
    else $error("result loaded outside final state");
`endif

endmodule
